// ----- rtl/core/tlvc_pkg.sv -----
// ----------------------------------------------------------------------------
// tlvc_pkg
// Shared constants, types and the signature table of the TLV image checker.
// ----------------------------------------------------------------------------
package tlvc_pkg;

    // image size and derived widths
    localparam int IMAGE_BYTES = 2048;
    localparam int OFF_W       = $clog2(IMAGE_BYTES + 257);
    localparam int TL_W        = 16;
    localparam int CMP_W       = TL_W + 1;
    localparam int HDR_BYTES   = 11;
    localparam int VOFF_W      = 11;

    // fixed codes of the image format
    localparam logic [7:0]  HDR_VERSION  = 8'h01;
    localparam logic [7:0]  TYPE_CRC     = 8'hFE;
    localparam logic [7:0]  LEN_CRC      = 8'h04;
    localparam logic [7:0]  TYPE_EMPTY   = 8'h00;
    localparam logic [7:0]  TYPE_ERASED  = 8'hFF;
    localparam logic [7:0]  WANTED_RESET = 8'h21;
    localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
    localparam logic [31:0] CRC_ONES     = 32'hFFFFFFFF;

    // result status codes
    typedef enum logic [2:0] {
        ST_FOUND     = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_BAD_HDR   = 3'd2,
        ST_BAD_CRC   = 3'd3,
        ST_BAD_TLV   = 3'd4,
        ST_TRUNCATED = 3'd5
    } t_status;

    // crc control from the parser
    typedef struct packed {
        logic take;
        logic clear;
    } t_crc_ctl;

    // one result item
    typedef struct packed {
        t_status             status;
        logic [VOFF_W-1:0]   value_offset;
        logic [7:0]          value_length;
        logic [63:0]         value_head;
    } t_result;

    // "TlvInfo" with its terminator
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h54;
            3'd1:    v = 8'h6C;
            3'd2:    v = 8'h76;
            3'd3:    v = 8'h49;
            3'd4:    v = 8'h6E;
            3'd5:    v = 8'h66;
            3'd6:    v = 8'h6F;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/tlvc_crc.sv -----
// ----------------------------------------------------------------------------
// tlvc_crc
// Byte-wide reflected CRC-32 register with final xor on its output.
// ----------------------------------------------------------------------------
module tlvc_crc (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [7:0]        i_byte,
    input  tlvc_pkg::t_crc_ctl i_ctl,
    output logic [31:0]       o_crc_final
);

    logic [31:0] r_crc;
    logic [31:0] n_crc;
    logic [31:0] crc_step;

    // eight bit steps of the reflected polynomial
    always_comb begin
        crc_step = r_crc ^ {24'h000000, i_byte};
        for (int k = 0; k < 8; k++) begin
            crc_step = crc_step[0] ? ((crc_step >> 1) ^ tlvc_pkg::CRC_POLY)
                                   : (crc_step >> 1);
        end
    end

    assign n_crc       = i_ctl.take ? crc_step : r_crc;
    assign o_crc_final = n_crc ^ tlvc_pkg::CRC_ONES;

    // crc register, back to all ones at the end of an image
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= tlvc_pkg::CRC_ONES;
        end else if (i_en) begin
            r_crc <= i_ctl.clear ? tlvc_pkg::CRC_ONES : n_crc;
        end
    end

endmodule

// ----- rtl/core/tlvc_parse.sv -----
// ----------------------------------------------------------------------------
// tlvc_parse
// Header check, crc record capture, TLV walk and status for each image byte.
// ----------------------------------------------------------------------------
module tlvc_parse (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    input  logic [7:0]           i_wanted,
    input  logic [31:0]          i_crc_final,
    output tlvc_pkg::t_crc_ctl   o_crc_ctl,
    output tlvc_pkg::t_result    o_result
);

    localparam int OW = tlvc_pkg::OFF_W;
    localparam int CW = tlvc_pkg::CMP_W;
    localparam int TW = tlvc_pkg::TL_W;

    typedef enum logic [1:0] {
        WALK_SEARCH = 2'd0,
        WALK_FOUND  = 2'd1,
        WALK_BAD    = 2'd2
    } t_walk;

    typedef tlvc_pkg::t_status t_status_l;

    logic [OW-1:0] r_pos,      n_pos;
    logic [TW-1:0] r_tl,       n_tl;
    logic [OW-1:0] r_nro,      n_nro;
    logic          r_hdr_ok,   n_hdr_ok;
    t_walk         r_walk,     n_walk;
    logic [7:0]    r_cur_type, n_cur_type;
    logic [31:0]   r_scrc,     n_scrc;
    logic          r_crec_ok,  n_crec_ok;
    logic [OW-1:0] r_moff,     n_moff;
    logic [7:0]    r_mlen,     n_mlen;
    logic [63:0]   r_mhead,    n_mhead;
    logic          r_len_pend, n_len_pend;

    logic [CW-1:0] p_x;
    logic [CW-1:0] tl_x;
    logic [CW-1:0] area_end;
    logic          in_area;
    logic [OW-1:0] head_idx;
    t_status_l     status;

    // next state of one byte step
    always_comb begin
        n_pos      = (r_pos == {OW{1'b1}}) ? r_pos : r_pos + OW'(1);
        n_tl       = r_tl;
        n_nro      = r_nro;
        n_hdr_ok   = r_hdr_ok;
        n_walk     = r_walk;
        n_cur_type = r_cur_type;
        n_scrc     = r_scrc;
        n_crec_ok  = r_crec_ok;
        n_moff     = r_moff;
        n_mlen     = r_mlen;
        n_mhead    = r_mhead;
        n_len_pend = r_len_pend;
        head_idx   = r_pos - r_moff;

        // header fields
        if (r_pos < OW'(8)) begin
            if (i_byte != tlvc_pkg::sig_byte(r_pos[2:0])) begin
                n_hdr_ok = 1'b0;
            end
        end else if (r_pos == OW'(8)) begin
            if (i_byte != tlvc_pkg::HDR_VERSION) begin
                n_hdr_ok = 1'b0;
            end
        end else if (r_pos == OW'(9)) begin
            n_tl = {i_byte, 8'h00};
        end else if (r_pos == OW'(10)) begin
            n_tl = r_tl | TW'(i_byte);
            if (n_tl > TW'(tlvc_pkg::IMAGE_BYTES - tlvc_pkg::HDR_BYTES)) begin
                n_hdr_ok = 1'b0;
            end
        end

        p_x      = CW'(r_pos);
        tl_x     = CW'(n_tl);
        area_end = tl_x + CW'(tlvc_pkg::HDR_BYTES);
        in_area  = (r_pos >= OW'(tlvc_pkg::HDR_BYTES)) && n_hdr_ok && (p_x < area_end);

        if (in_area) begin
            // crc record at the end of the record area
            if (n_tl >= TW'(6)) begin
                if (p_x == tl_x + CW'(5)) begin
                    n_crec_ok = (i_byte == tlvc_pkg::TYPE_CRC);
                end else if (p_x == tl_x + CW'(6)) begin
                    n_crec_ok = r_crec_ok && (i_byte == tlvc_pkg::LEN_CRC);
                end else if (p_x >= tl_x + CW'(7)) begin
                    n_scrc = {r_scrc[23:0], i_byte};
                end
            end
            // record walk
            case (r_walk)
                WALK_SEARCH: begin
                    if (r_len_pend) begin
                        n_nro      = r_pos + OW'(1) + OW'(i_byte);
                        n_len_pend = 1'b0;
                    end else if (r_pos == r_nro) begin
                        n_cur_type = i_byte;
                        if (i_byte == tlvc_pkg::TYPE_EMPTY ||
                            i_byte == tlvc_pkg::TYPE_ERASED) begin
                            n_walk = WALK_BAD;
                        end else if (i_byte == i_wanted) begin
                            n_walk = WALK_FOUND;
                            n_moff = r_pos + OW'(2);
                        end else begin
                            n_len_pend = 1'b1;
                        end
                    end
                end
                WALK_FOUND: begin
                    if (r_pos + OW'(1) == r_moff) begin
                        n_mlen = i_byte;
                    end else if (r_pos >= r_moff) begin
                        if (head_idx < OW'(8) && head_idx < OW'(r_mlen)) begin
                            for (int k = 0; k < 8; k++) begin
                                if (head_idx[2:0] == 3'(k)) begin
                                    n_mhead[63-8*k -: 8] = r_mhead[63-8*k -: 8] | i_byte;
                                end
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // crc takes header bytes and the area up to the crc value
    assign o_crc_ctl.take  = (r_pos < OW'(tlvc_pkg::HDR_BYTES)) ||
                             (p_x < tl_x + CW'(7));
    assign o_crc_ctl.clear = i_last;

    // status in priority order
    always_comb begin
        if (n_pos < OW'(tlvc_pkg::HDR_BYTES)) begin
            status = tlvc_pkg::ST_TRUNCATED;
        end else if (!n_hdr_ok) begin
            status = tlvc_pkg::ST_BAD_HDR;
        end else if (n_tl < TW'(6)) begin
            status = tlvc_pkg::ST_BAD_CRC;
        end else if (CW'(n_pos) < area_end) begin
            status = tlvc_pkg::ST_TRUNCATED;
        end else if (!n_crec_ok || i_crc_final != n_scrc) begin
            status = tlvc_pkg::ST_BAD_CRC;
        end else if (n_walk == WALK_BAD) begin
            status = tlvc_pkg::ST_BAD_TLV;
        end else if (n_walk == WALK_FOUND) begin
            status = tlvc_pkg::ST_FOUND;
        end else begin
            status = tlvc_pkg::ST_NOT_FOUND;
        end
    end

    // result fields, zero unless a record was found
    always_comb begin
        o_result.status = status;
        if (status == tlvc_pkg::ST_FOUND) begin
            o_result.value_offset = n_moff[tlvc_pkg::VOFF_W-1:0];
            o_result.value_length = n_mlen;
            o_result.value_head   = n_mhead;
        end else begin
            o_result.value_offset = '0;
            o_result.value_length = '0;
            o_result.value_head   = '0;
        end
    end

    // parser state, cleared at reset and after the last byte of an image
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && i_last)) begin
            r_pos      <= '0;
            r_tl       <= '0;
            r_nro      <= OW'(tlvc_pkg::HDR_BYTES);
            r_hdr_ok   <= 1'b1;
            r_walk     <= WALK_SEARCH;
            r_cur_type <= '0;
            r_scrc     <= '0;
            r_crec_ok  <= 1'b0;
            r_moff     <= '0;
            r_mlen     <= '0;
            r_mhead    <= '0;
            r_len_pend <= 1'b0;
        end else if (i_en) begin
            r_pos      <= n_pos;
            r_tl       <= n_tl;
            r_nro      <= n_nro;
            r_hdr_ok   <= n_hdr_ok;
            r_walk     <= n_walk;
            r_cur_type <= n_cur_type;
            r_scrc     <= n_scrc;
            r_crec_ok  <= n_crec_ok;
            r_moff     <= n_moff;
            r_mlen     <= n_mlen;
            r_mhead    <= n_mhead;
            r_len_pend <= n_len_pend;
        end
    end

`ifndef SYNTH
    // a record found always has its type byte seen as the wanted code
    a_found_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && !i_last && r_walk == WALK_SEARCH && n_walk == WALK_FOUND)
        |=> (r_cur_type == $past(i_wanted)))
        else $error("found record type differs from wanted type");

    // a length byte is only pending while still searching
    a_pend_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len_pend |-> (r_walk == WALK_SEARCH))
        else $error("length pending outside search");
`endif

endmodule

// ----- rtl/core/tlv_eeprom_image_checker.sv -----
// ----------------------------------------------------------------------------
// tlv_eeprom_image_checker
// Checks a TLV EEPROM image byte by byte and reports the wanted record.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (i_in_valid / o_in_ready) carries one image byte per
//   item, from offset zero, with i_last_byte set on the final byte. Each byte
//   is taken into an input register and from there processed by the
//   header/walk logic and the byte-wide crc unit; one byte per cycle is
//   sustained without bubbles except while a final byte is held (below).
//   Only the final byte of an image gives a result item on the output channel
//   (o_out_valid / i_out_ready), held in the result register: the status,
//   the value offset, the length byte and up to eight value bytes.
//   Non-zero status codes come with all value fields at zero.
//   A result waits in the output register while the receiver stalls; bytes
//   keep flowing meanwhile and only the next final byte is held in the input
//   register until the result ahead of it is taken.
//   i_cfg_we writes the wanted type code from i_cfg_data; the user must
//   write it between images, as the block itself does not enforce this.
//   A synchronous reset (i_rst_n low) empties both registers, sets the wanted
//   type to 0x21 and starts a fresh image; each final byte does the same for
//   the parser and crc state.
// ----------------------------------------------------------------------------
module tlv_eeprom_image_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [10:0] o_value_offset,
    output logic [7:0]  o_value_length,
    output logic [63:0] o_value_head
);

    logic                r_wanted;
    logic [7:0]          r_wanted_type;
    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_in_last;
    logic                r_out_valid;
    tlvc_pkg::t_result   r_out;
    logic                advance;
    tlvc_pkg::t_crc_ctl  crc_ctl;
    logic [31:0]         crc_final;
    tlvc_pkg::t_result   result;

    // a final byte moves only when the output slot is free or draining
    assign advance    = r_in_valid && (!r_in_last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wanted_type <= tlvc_pkg::WANTED_RESET;
            r_wanted      <= 1'b0;
        end else if (i_cfg_we) begin
            r_wanted_type <= i_cfg_data;
            r_wanted      <= 1'b1;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    tlvc_crc u_crc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_byte      (r_in_byte),
        .i_ctl       (crc_ctl),
        .o_crc_final (crc_final)
    );

    tlvc_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_byte      (r_in_byte),
        .i_last      (r_in_last),
        .i_wanted    (r_wanted_type),
        .i_crc_final (crc_final),
        .o_crc_ctl   (crc_ctl),
        .o_result    (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out <= result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out.status;
    assign o_value_offset = r_out.value_offset;
    assign o_value_length = r_out.value_length;
    assign o_value_head   = r_out.value_head;

`ifndef SYNTH
    // a final byte that moves always leaves a result behind
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |=> r_out_valid)
        else $error("final item gave no result");

    // input stalls only on a final byte behind an untaken result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_in_last && r_out_valid && !i_out_ready))
        else $error("input stalled without cause");

    // value fields are zero unless the record was found
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != tlvc_pkg::ST_FOUND) |->
        (r_out.value_offset == '0 && r_out.value_length == '0 &&
         r_out.value_head == '0))
        else $error("value fields set on a failed result");

    // the wanted type only leaves its reset value through a write
    a_cfg_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_wanted) |-> (r_wanted_type == tlvc_pkg::WANTED_RESET))
        else $error("wanted type changed without a write");
`endif

endmodule
